// ===== hdl/sv39_page_table_mapper_macros.svh =====
// assertion macros for the sv39 page table mapper
// used by the top level only
`ifndef SV39_PAGE_TABLE_MAPPER_MACROS_SVH
`define SV39_PAGE_TABLE_MAPPER_MACROS_SVH

// check a property under the synchronous reset
`define SPTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication on the next cycle
`define SPTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sptm_pkg.sv =====
// shared types and constants for the sv39 page table mapper
// no dependencies
`default_nettype none
package sptm_pkg;
  localparam int POOL_PAGES = 64;
  localparam int PAGE_W = $clog2(POOL_PAGES);
  localparam int IDX_W = 9;
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int PPN_SHIFT = 10;
  localparam int IN_W = 136;   // op, va, pa, perm, page_count = 116 bits, padded
  localparam int OUT_W = 80;   // status, pte_value, pages_done = 76 bits, padded

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_POOL = 2'd1, ST_LEAF = 2'd2, ST_UNMAPPED = 2'd3
  } status_t;

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/sv39_page_table_mapper.sv =====
// sv39 page table mapper top level: walker fsm around one table memory
// depends on sptm_pkg and sv39_page_table_mapper_macros.svh
//
// channel | ports                          | word
// input   | in_tvalid in_tready in_tdata   | op, va, pa, perm, page_count
// output  | out_tvalid out_tready out_tdata| status, pte_value, pages_done
//
// after reset a clearing pass writes the root page; no input is taken meanwhile.
// lookup: up to three reads, each through rd, wait and eval, then done and idle.
// map: a walk of three reads per page; each newly allocated table page adds a clearing pass and a link write.
// one item at a time; the next item is taken once the result sits in the
// output register, even while out_tready is low; its own result then waits in done.
`default_nettype none
`include "sv39_page_table_mapper_macros.svh"
module sv39_page_table_mapper (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // op[0], va[39:1], pa[95:40], perm[105:96], page_count[115:106]
  input  wire logic [sptm_pkg::IN_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // status[1:0], pte_value[65:2], pages_done[75:66]
  output logic [sptm_pkg::OUT_W-1:0]    out_tdata
);
  import sptm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EVAL, S_ALLOC, S_LINK, S_DONE
  } state_t;

  logic [63:0] mem [0:POOL_PAGES*512-1];
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [63:0] rd_data_r, wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  state_t state_r;
  logic op_r;
  logic [38:0] va_r;
  logic [55:0] pa_r;
  logic [9:0] perm_r, count_r, done_r;
  logic [1:0] level_r;          // 2, 1, 0 = leaf
  logic [PAGE_W-1:0] page_r, fresh_r;
  logic [PAGE_W:0] next_free_r;
  logic pool_exh_r;
  logic [IDX_W-1:0] clr_r;
  logic [ADDR_W-1:0] pos_r;
  logic [1:0] status_r;
  logic [63:0] pte_r;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [IDX_W-1:0] idx;
  logic [63:0] leaf;
  logic [53:0] ppn;

  always_comb begin
    unique case (level_r)
      2'd2: idx = va_r[38:30];
      2'd1: idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
    leaf = {10'd0, pa_r[55:12], perm_r | 10'd1};
    ppn = rd_data_r[63:10];
  end

  assign rd_addr = {page_r, idx};
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos_r;
    wr_data = 64'd0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = {fresh_r, clr_r};
      end
      S_ALLOC: begin
        wr_en = 1'b1;
        wr_addr = {fresh_r, clr_r};
      end
      S_LINK: begin
        wr_en = 1'b1;
        wr_data = {{(54-PAGE_W){1'b0}}, fresh_r, 10'd1};
      end
      S_EVAL: begin
        if (level_r == 2'd0 && op_r == OP_MAP && !rd_data_r[0]) begin
          wr_en = 1'b1;
          wr_data = leaf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      fresh_r <= '0;
      next_free_r <= (PAGE_W+1)'(1);
      pool_exh_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r <= '0;
      page_r <= '0;
      level_r <= 2'd2;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[0];
            va_r <= in_tdata[39:1];
            pa_r <= in_tdata[95:40];
            perm_r <= in_tdata[105:96];
            count_r <= in_tdata[115:106];
            done_r <= '0;
            pte_r <= '0;
            status_r <= ST_OK;
            page_r <= '0;
            level_r <= 2'd2;
            if (in_tdata[0] == OP_MAP && in_tdata[115:106] == 10'd0) state_r <= S_DONE;
            else state_r <= S_RD;
          end
        end
        S_RD: begin
          pos_r <= rd_addr;
          state_r <= S_WAIT;
        end
        S_WAIT: state_r <= S_EVAL;
        S_EVAL: begin
          if (level_r != 2'd0) begin
            if (rd_data_r[0]) begin
              if (ppn >= 54'(POOL_PAGES)) begin
                status_r <= (op_r == OP_LOOKUP) ? ST_UNMAPPED : ST_POOL;
                state_r <= S_DONE;
              end else begin
                page_r <= ppn[PAGE_W-1:0];
                level_r <= level_r - 1'b1;
                state_r <= S_RD;
              end
            end else if (op_r == OP_LOOKUP) begin
              status_r <= ST_UNMAPPED;
              state_r <= S_DONE;
            end else if (next_free_r >= (PAGE_W+1)'(POOL_PAGES)) begin
              pool_exh_r <= 1'b1;
              status_r <= ST_POOL;
              state_r <= S_DONE;
            end else begin
              fresh_r <= next_free_r[PAGE_W-1:0];
              next_free_r <= next_free_r + 1'b1;
              clr_r <= '0;
              state_r <= S_ALLOC;
            end
          end else if (op_r == OP_LOOKUP) begin
            if (rd_data_r[0]) pte_r <= rd_data_r;
            else status_r <= ST_UNMAPPED;
            state_r <= S_DONE;
          end else if (rd_data_r[0]) begin
            status_r <= ST_LEAF;
            state_r <= S_DONE;
          end else begin
            pte_r <= leaf;
            done_r <= done_r + 1'b1;
            va_r <= va_r + 39'h1000;
            pa_r <= pa_r + 56'h1000;
            page_r <= '0;
            level_r <= 2'd2;
            if (done_r + 1'b1 == count_r) state_r <= S_DONE;
            else state_r <= S_RD;
          end
        end
        S_ALLOC: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_LINK;
        end
        S_LINK: begin
          page_r <= fresh_r;
          level_r <= level_r - 1'b1;
          state_r <= S_RD;
        end
        S_DONE: begin
          // result waits here while the output register is still taken
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r <= {4'd0, done_r, pte_r, status_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SPTM_ASSERT(a_no_accept_busy, !(in_tvalid && in_tready && state_r != S_IDLE), "accept while busy")
  `SPTM_ASSERT(a_pool_bound, next_free_r <= (PAGE_W+1)'(POOL_PAGES), "pool counter overrun")
  `SPTM_ASSERT(a_exh_full, !pool_exh_r || next_free_r == (PAGE_W+1)'(POOL_PAGES), "exhausted flag early")
  `SPTM_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(out_tdata), "result dropped")
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking bench for sv39_page_table_mapper: directed and random map/lookup words
// keeps its own copy of the table pool and checks every result in order
// depends on sptm_pkg
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import sptm_pkg::*;

  typedef struct {
    logic        op;
    logic [38:0] va;
    logic [55:0] pa;
    logic [9:0]  perm;
    logic [9:0]  count;
  } walk_req_t;

  typedef struct {
    status_t     status;
    logic [63:0] pte;
    logic [9:0]  done;
  } walk_res_t;

  class walk_scoreboard;
    logic [63:0] tbl [POOL_PAGES*512];
    int unsigned next_free;
    walk_res_t   pending_q[$];
    int unsigned errors;

    function new();
      foreach (tbl[i]) tbl[i] = '0;
      next_free = 1;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // walk the two interior levels, allocating cleared pages if asked
    function bit find_slot(logic [38:0] va, bit alloc, output int unsigned slot);
      int unsigned page;
      int unsigned pos;
      logic [63:0] e;
      page = 0;
      slot = 0;
      for (int lvl = 2; lvl > 0; lvl--) begin
        pos = page*512 + 32'((va >> (12 + 9*lvl)) & 39'h1FF);
        e = tbl[pos];
        if (e[0]) begin
          if ((e >> PPN_SHIFT) >= POOL_PAGES) return 0;
          page = 32'(e >> PPN_SHIFT);
        end else begin
          if (!alloc || next_free >= POOL_PAGES) return 0;
          page = next_free;
          next_free++;
          for (int k = 0; k < 512; k++) tbl[page*512 + k] = '0;
          tbl[pos] = (64'(page) << PPN_SHIFT) | 64'd1;
        end
      end
      slot = page*512 + 32'(va[20:12]);
      return 1;
    endfunction

    function void note_input(walk_req_t r);
      walk_res_t   x;
      int unsigned slot;
      logic [38:0] va;
      logic [55:0] pa;
      logic [63:0] leaf;
      x.status = ST_OK;
      x.pte = '0;
      x.done = '0;
      va = r.va;
      pa = r.pa;
      if (r.op == OP_LOOKUP) begin
        if (find_slot(va, 0, slot) && tbl[slot][0]) x.pte = tbl[slot];
        else x.status = ST_UNMAPPED;
      end else begin
        while (x.done < r.count) begin
          if (!find_slot(va, 1, slot)) begin
            x.status = ST_POOL;
            break;
          end
          if (tbl[slot][0]) begin
            x.status = ST_LEAF;
            break;
          end
          leaf = (64'(pa >> 12) << PPN_SHIFT) | 64'(r.perm) | 64'd1;
          tbl[slot] = leaf;
          x.pte = leaf;
          x.done++;
          va = va + 39'h1000;
          pa = pa + 56'h1000;
        end
      end
      pending_q.push_back(x);
    endfunction

    task check_result(logic [OUT_W-1:0] d);
      walk_res_t x;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result word %h", d));
        return;
      end
      x = pending_q.pop_front();
      if (d[1:0] != x.status)
        report($sformatf("status %0d, want %0d", d[1:0], x.status));
      if (d[65:2] != x.pte)
        report($sformatf("pte_value %h, want %h", d[65:2], x.pte));
      if (d[75:66] != x.done)
        report($sformatf("pages_done %0d, want %0d", d[75:66], x.done));
    endtask
  endclass

  logic clk = 0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  walk_scoreboard sb = new();
  int unsigned sent_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  bit held_once = 0;
  logic [38:0] mapped_va_q[$];

  sv39_page_table_mapper uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // idle mix changes every 250 words: none, sender, receiver, both
  always @(posedge clk) begin
    case ((sent_count / 250) % 4)
      0: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
      1: begin send_idle_pct <= 69; recv_stall_pct <= 0; end
      2: begin send_idle_pct <= 0; recv_stall_pct <= 69; end
      default: begin send_idle_pct <= 9; recv_stall_pct <= 9; end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else if (!held_once && sent_count >= 600) begin
      // long hold-off so the block backs up into its input
      held_once <= 1;
      hold_cycles <= 400;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task send(walk_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {20'd0, r.count, r.perm, r.pa, r.va, r.op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(r);
    sent_count++;
  endtask

  task send_fields(logic op, logic [38:0] va, logic [55:0] pa, logic [9:0] perm,
                   logic [9:0] count);
    walk_req_t r;
    r.op = op;
    r.va = va;
    r.pa = pa;
    r.perm = perm;
    r.count = count;
    if (op == OP_MAP) mapped_va_q.push_back(va);
    send(r);
  endtask

  function logic [38:0] pick_va();
    logic [8:0] top;
    if ($urandom_range(0, 99) < 25) return 39'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: top = 9'd0;
      1: top = 9'd1;
      2: top = 9'h1FF;
      default: top = 9'd77;
    endcase
    return {top, 9'($urandom_range(0, 7)), 9'($urandom), 12'($urandom)};
  endfunction

  function logic [9:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 1) return 10'd0;
    if (r < 88) return 10'($urandom_range(1, 8));
    if (r < 97) return 10'($urandom_range(9, 64));
    return 10'($urandom_range(65, 1023));
  endfunction

  initial begin
    logic [38:0] va;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    send_fields(OP_LOOKUP, 39'd0, '0, '0, 10'd1);
    send_fields(OP_MAP, 39'd0, 56'd0, 10'd0, 10'd1);
    send_fields(OP_LOOKUP, 39'd0, '0, '0, 10'd0);
    send_fields(OP_MAP, {39{1'b1}}, {56{1'b1}}, 10'h3FF, 10'd1);
    send_fields(OP_LOOKUP, {39{1'b1}}, {56{1'b1}}, 10'h3FF, 10'h3FF);
    // remapping a live leaf
    send_fields(OP_MAP, 39'h0000000ABC, 56'h123000, 10'h0CE, 10'd1);
    send_fields(OP_MAP, 39'h0000100000, 56'h5000, 10'h00F, 10'd0);
    // runs into the leaf at the top of the space after two pages
    send_fields(OP_MAP, 39'h7FFFFFD000, 56'h9000, 10'h155, 10'd3);
    send_fields(OP_LOOKUP, 39'h7FFFFFE000, '0, '0, 10'd0);
    // long run with pa wrapping past the top of its range
    send_fields(OP_MAP, 39'h0040000000, 56'hFFFFFFFFFF0000, 10'h2AA, 10'h3FF);
    send_fields(OP_LOOKUP, 39'h00400FF000, '0, '0, 10'd0);
    send_fields(OP_LOOKUP, 39'h00403FE000, '0, '0, 10'd0);
    send_fields(OP_LOOKUP, 39'h00403FF000, '0, '0, 10'd0);
    send_fields(OP_MAP, 39'h0010000000, 56'h00ABCDEF000000, 10'h3FE, 10'd512);
    send_fields(OP_LOOKUP, 39'h00101FFFFF, '0, '0, 10'd0);
    send_fields(OP_LOOKUP, 39'h0010200000, '0, '0, 10'd0);
    // lookups that find no leaf
    send_fields(OP_LOOKUP, 39'h0000001000, '0, '0, 10'd0);
    send_fields(OP_LOOKUP, 39'h4000000000, '0, '0, 10'd0);

    repeat (1700) begin
      if ($urandom_range(0, 99) < 55) begin
        send_fields(OP_MAP, pick_va(), 56'({$urandom, $urandom}), 10'($urandom),
                    pick_count());
      end else begin
        if (mapped_va_q.size() > 0 && $urandom_range(0, 1))
          va = mapped_va_q[$urandom_range(0, mapped_va_q.size() - 1)]
               + 39'($urandom_range(0, 4) << 12);
        else
          va = pick_va();
        send_fields(OP_LOOKUP, va, 56'({$urandom, $urandom}), 10'($urandom),
                    10'($urandom));
      end
    end
    in_tvalid <= 0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
